>>> src/crs_pkg.sv
// ----------------------------------------------------------------------------
// crs_pkg
// Shared types and constants of the cursor ring store: sizes, request and
// status codes, and the structs that pass between the sequencer and the
// link memory.
// ----------------------------------------------------------------------------
package crs_pkg;

   localparam int CAPACITY   = 16;
   localparam int ELEM_WIDTH = 32;
   localparam int SLOT_W     = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);

   // Widths of the fields on the ports.
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 5;

   typedef enum logic [1:0] {
      REQ_NEXT   = 2'd0,
      REQ_ADD    = 2'd1,
      REQ_REMOVE = 2'd2,
      REQ_BACK   = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_FULL     = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   typedef logic [SLOT_W-1:0]     slot_type;
   typedef logic [ELEM_WIDTH-1:0] elem_type;
   typedef logic [CNT_W-1:0]      count_type;

   // Read address and three independent write ports of the link memory.
   typedef struct packed {
      slot_type raddr;
      logic     val_we;
      slot_type val_waddr;
      elem_type val_wdata;
      logic     nxt_we;
      slot_type nxt_waddr;
      slot_type nxt_wdata;
      logic     prv_we;
      slot_type prv_waddr;
      slot_type prv_wdata;
   } mem_cmd_type;

   typedef struct packed {
      elem_type value;
      slot_type nxt;
      slot_type prv;
   } mem_rd_type;

   typedef struct packed {
      status_type status;
      elem_type   elem;
      count_type  count;
      logic       has_mark;
      elem_type   mark_val;
   } result_type;

endpackage

>>> src/crs_link_mem.sv
// ----------------------------------------------------------------------------
// crs_link_mem
// Slot storage of the ring: value, forward link and backward link of each
// slot. One shared read address with registered data, one write port per
// array.
// ----------------------------------------------------------------------------
module crs_link_mem
   import crs_pkg::*;
(
   input  logic        clock,
   input  mem_cmd_type cmd,
   output mem_rd_type  rd
);

   elem_type value_mem_ff [CAPACITY];
   slot_type next_mem_ff  [CAPACITY];
   slot_type prev_mem_ff  [CAPACITY];
   mem_rd_type rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.val_we) begin
         value_mem_ff[cmd.val_waddr] <= cmd.val_wdata;
      end
      if (cmd.nxt_we) begin
         next_mem_ff[cmd.nxt_waddr] <= cmd.nxt_wdata;
      end
      if (cmd.prv_we) begin
         prev_mem_ff[cmd.prv_waddr] <= cmd.prv_wdata;
      end
      rd_ff.value <= value_mem_ff[cmd.raddr];
      rd_ff.nxt   <= next_mem_ff[cmd.raddr];
      rd_ff.prv   <= prev_mem_ff[cmd.raddr];
   end

   assign rd = rd_ff;

endmodule

>>> src/crs_seq.sv
// ----------------------------------------------------------------------------
// crs_seq
// Sequencer of the ring: keeps head, marker, count and slot occupancy,
// walks the links one slot per cycle through the link memory and drives
// the single value comparator used by the remove search.
// ----------------------------------------------------------------------------
module crs_seq
   import crs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  req_kind_type start_kind,
   input  elem_type     start_value,
   output logic         idle,
   output logic         res_valid,
   input  logic         res_ready,
   output result_type   res,
   output mem_cmd_type  mem_cmd,
   input  mem_rd_type   mem_rd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_LINK,
      S_DONE
   } state_type;

   state_type             state_ff,      state_in;
   req_kind_type          kind_ff,       kind_in;
   elem_type              value_ff,      value_in;
   slot_type              head_ff,       head_in;
   slot_type              mark_slot_ff,  mark_slot_in;
   logic                  mark_valid_ff, mark_valid_in;
   elem_type              mark_val_ff,   mark_val_in;
   count_type             count_ff,      count_in;
   logic [CAPACITY-1:0]   used_ff,       used_in;
   slot_type              cur_ff,        cur_in;
   count_type             iter_ff,       iter_in;
   slot_type              free_ff,       free_in;
   slot_type              prev_ff,       prev_in;
   status_type            status_ff,     status_in;
   elem_type              elem_ff,       elem_in;

   slot_type free_slot;
   logic     free_any;

   // Lowest-numbered free slot.
   always_comb begin
      free_slot = '0;
      free_any  = 1'b0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_slot = SLOT_W'(i);
            free_any  = 1'b1;
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      value_in      = value_ff;
      head_in       = head_ff;
      mark_slot_in  = mark_slot_ff;
      mark_valid_in = mark_valid_ff;
      mark_val_in   = mark_val_ff;
      count_in      = count_ff;
      used_in       = used_ff;
      cur_in        = cur_ff;
      iter_in       = iter_ff;
      free_in       = free_ff;
      prev_in       = prev_ff;
      status_in     = status_ff;
      elem_in       = elem_ff;
      mem_cmd       = '0;
      mem_cmd.raddr = head_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               kind_in   = start_kind;
               value_in  = start_value;
               free_in   = free_slot;
               cur_in    = head_ff;
               iter_in   = '0;
               elem_in   = '0;
               status_in = ST_OK;
               if (start_kind != REQ_ADD && count_ff == '0) begin
                  status_in = ST_EMPTY;
                  state_in  = S_DONE;
               end else if (start_kind == REQ_ADD && !free_any) begin
                  status_in = ST_FULL;
                  state_in  = S_DONE;
               end else if (start_kind == REQ_ADD && count_ff == '0) begin
                  // First element links to itself in both directions.
                  mem_cmd.val_we    = 1'b1;
                  mem_cmd.val_waddr = free_slot;
                  mem_cmd.val_wdata = start_value;
                  mem_cmd.nxt_we    = 1'b1;
                  mem_cmd.nxt_waddr = free_slot;
                  mem_cmd.nxt_wdata = free_slot;
                  mem_cmd.prv_we    = 1'b1;
                  mem_cmd.prv_waddr = free_slot;
                  mem_cmd.prv_wdata = free_slot;
                  used_in[free_slot] = 1'b1;
                  head_in   = free_slot;
                  count_in  = CNT_W'(1);
                  state_in  = S_DONE;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end

         S_EXEC: begin
            case (kind_ff)
               REQ_NEXT: begin
                  elem_in       = mem_rd.value;
                  mark_slot_in  = head_ff;
                  mark_valid_in = 1'b1;
                  mark_val_in   = mem_rd.value;
                  head_in       = mem_rd.nxt;
                  state_in      = S_DONE;
               end
               REQ_BACK: begin
                  head_in  = mem_rd.prv;
                  state_in = S_DONE;
               end
               REQ_ADD: begin
                  // New slot sits between the old head's predecessor and the head.
                  mem_cmd.val_we    = 1'b1;
                  mem_cmd.val_waddr = free_ff;
                  mem_cmd.val_wdata = value_ff;
                  mem_cmd.nxt_we    = 1'b1;
                  mem_cmd.nxt_waddr = free_ff;
                  mem_cmd.nxt_wdata = head_ff;
                  mem_cmd.prv_we    = 1'b1;
                  mem_cmd.prv_waddr = free_ff;
                  mem_cmd.prv_wdata = mem_rd.prv;
                  prev_in  = mem_rd.prv;
                  state_in = S_LINK;
               end
               REQ_REMOVE: begin
                  if (mem_rd.value == value_ff) begin
                     mem_cmd.nxt_we    = 1'b1;
                     mem_cmd.nxt_waddr = mem_rd.prv;
                     mem_cmd.nxt_wdata = mem_rd.nxt;
                     mem_cmd.prv_we    = 1'b1;
                     mem_cmd.prv_waddr = mem_rd.nxt;
                     mem_cmd.prv_wdata = mem_rd.prv;
                     used_in[cur_ff]   = 1'b0;
                     if (cur_ff == head_ff) begin
                        head_in = mem_rd.nxt;
                     end
                     if (mark_valid_ff && mark_slot_ff == cur_ff) begin
                        mark_valid_in = 1'b0;
                     end
                     count_in = count_ff - CNT_W'(1);
                     if (count_ff == CNT_W'(1)) begin
                        head_in       = '0;
                        mark_valid_in = 1'b0;
                     end
                     state_in = S_DONE;
                  end else if ((iter_ff + CNT_W'(1)) >= count_ff) begin
                     status_in = ST_NOTFOUND;
                     state_in  = S_DONE;
                  end else begin
                     // Follow the forward link; data arrives next cycle.
                     mem_cmd.raddr = mem_rd.nxt;
                     cur_in        = mem_rd.nxt;
                     iter_in       = iter_ff + CNT_W'(1);
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end

         S_LINK: begin
            mem_cmd.prv_we     = 1'b1;
            mem_cmd.prv_waddr  = head_ff;
            mem_cmd.prv_wdata  = free_ff;
            mem_cmd.nxt_we     = 1'b1;
            mem_cmd.nxt_waddr  = prev_ff;
            mem_cmd.nxt_wdata  = free_ff;
            used_in[free_ff]   = 1'b1;
            head_in            = free_ff;
            count_in           = count_ff + CNT_W'(1);
            state_in           = S_DONE;
         end

         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         mark_slot_ff  <= '0;
         mark_valid_ff <= 1'b0;
         count_ff      <= '0;
         used_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         mark_slot_ff  <= mark_slot_in;
         mark_valid_ff <= mark_valid_in;
         count_ff      <= count_in;
         used_ff       <= used_in;
      end
      kind_ff     <= kind_in;
      value_ff    <= value_in;
      mark_val_ff <= mark_val_in;
      cur_ff      <= cur_in;
      iter_ff     <= iter_in;
      free_ff     <= free_in;
      prev_ff     <= prev_in;
      status_ff   <= status_in;
      elem_ff     <= elem_in;
   end

   assign idle         = (state_ff == S_IDLE);
   assign res_valid    = (state_ff == S_DONE);
   assign res.status   = status_ff;
   assign res.elem     = elem_ff;
   assign res.count    = count_ff;
   assign res.has_mark = mark_valid_ff;
   assign res.mark_val = mark_valid_ff ? mark_val_ff : '0;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("element count above capacity");

   a_used_matches_count: assert property (@(posedge clock) disable iff (reset)
      $countones(used_ff) == int'(count_ff))
      else $error("occupied slots disagree with element count");

   a_mark_on_used: assert property (@(posedge clock) disable iff (reset)
      mark_valid_ff |-> used_ff[mark_slot_ff])
      else $error("marker points at a free slot");

   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> (head_ff == '0 && !mark_valid_ff))
      else $error("empty ring with nonzero head or live marker");

endmodule

>>> src/cursor_ring_store_unit.sv
// ----------------------------------------------------------------------------
// cursor_ring_store_unit
// Bounded circular doubly linked ring with a head cursor and a marker on the
// value last handed out. Requests are next, add, remove by value and back.
// ----------------------------------------------------------------------------
// From a request transfer, an error or an add to an empty ring goes straight to
// S_DONE; next and back pass through S_EXEC, add through S_EXEC and S_LINK, and
// remove stays in S_EXEC, walking from the head, until a hit or all are tried.
// One request at a time: the next request can be taken the cycle after the result
// moves into the output register, not before the last one is through the sequencer.
// Synchronous active-high reset empties the ring and clears the marker.
module cursor_ring_store_unit
   import crs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [31:0] elem_out, [36:32] ring_count,
                                    // [68:37] marker_value, [71:69] zero
   output logic [2:0]  rsp_tuser    // [1:0] status, [2] has_marker
);

   logic        seq_idle;
   logic        res_valid;
   logic        res_ready;
   result_type  res;
   mem_cmd_type mem_cmd;
   mem_rd_type  mem_rd;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [71:0] rsp_data_ff,  rsp_data_in;
   logic [2:0]  rsp_user_ff,  rsp_user_in;

   crs_link_mem u_mem (
      .clock (clock),
      .cmd   (mem_cmd),
      .rd    (mem_rd)
   );

   crs_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (req_tvalid && seq_idle),
      .start_kind  (req_kind_type'(req_tuser)),
      .start_value (ELEM_WIDTH'(req_tdata)),
      .idle        (seq_idle),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res),
      .mem_cmd     (mem_cmd),
      .mem_rd      (mem_rd)
   );

   assign req_tready = seq_idle;

   // The output register frees the sequencer as soon as a result is loaded.
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {3'b000, VALUE_W'(res.mark_val), COUNT_W'(res.count),
                         VALUE_W'(res.elem)};
         rsp_user_in  = {res.has_mark, res.status};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

>>> tb/sv/cursor_ring_store_unit_tb.sv
// ----------------------------------------------------------------------------
// cursor_ring_store_unit_tb
// Self-checking bench for the cursor ring store. A negedge driver sends
// next, add, remove and back requests from a queue that is filled before
// reset: first a directed pass over the error cases, the marker rules and a
// full ring, then bursts biased toward filling, draining or a mix. The values
// mostly come from a small pool so that removes often hit. Each accepted
// request is run through a slot-level model of the ring, and every result is
// checked field by field against the oldest prediction. Both sides idle at
// random. The receiver holds off twice for a long stretch, and the sender
// waits at times until every result has come back.
// ----------------------------------------------------------------------------
module cursor_ring_store_unit_tb
   import crs_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 1525;
   localparam int POOL_SIZE    = 20;
   localparam int STALL_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 40;
   localparam int REPORT_MAX   = 10;

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_type;

   typedef struct {
      req_kind_type      op;
      logic [VALUE_W-1:0] value;
      bit                sync;
   } ring_req_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic [2:0]  rsp_tuser;

   ring_req_type pending_reqs[$];
   result_type   expected_results[$];
   logic [VALUE_W-1:0] value_pool[POOL_SIZE];

   // Shadow of the ring, updated once per accepted request.
   logic [VALUE_W-1:0] ring_val[CAPACITY];
   bit [SLOT_W-1:0]    ring_nxt[CAPACITY];
   bit [SLOT_W-1:0]    ring_prv[CAPACITY];
   bit                 ring_busy[CAPACITY];
   bit [SLOT_W-1:0]    ring_head    = '0;
   bit [SLOT_W-1:0]    ring_mark    = '0;
   bit                 ring_mark_on = 1'b0;
   int                 ring_count   = 0;

   bit req_taken    = 1'b0;
   int results_seen = 0;
   int fail_count   = 0;
   int idle_cycles  = 0;

   cursor_ring_store_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   function automatic result_type ring_apply(req_kind_type op, logic [VALUE_W-1:0] v);
      result_type      res;
      int              free_slot;
      int              i;
      bit [SLOT_W-1:0] s;
      bit [SLOT_W-1:0] p;
      bit [SLOT_W-1:0] n;
      bit              hit;
      res        = '0;
      res.status = ST_OK;
      case (op)
         REQ_NEXT: begin
            if (ring_count == 0) begin
               res.status = ST_EMPTY;
            end else begin
               res.elem     = ring_val[ring_head];
               ring_mark    = ring_head;
               ring_mark_on = 1'b1;
               ring_head    = ring_nxt[ring_head];
            end
         end
         REQ_ADD: begin
            // The lowest free slot is taken.
            free_slot = -1;
            for (i = CAPACITY - 1; i >= 0; i--) begin
               if (!ring_busy[i]) free_slot = i;
            end
            if (free_slot < 0) begin
               res.status = ST_FULL;
            end else begin
               s            = free_slot[SLOT_W-1:0];
               ring_busy[s] = 1'b1;
               ring_val[s]  = v;
               if (ring_count == 0) begin
                  ring_nxt[s] = s;
                  ring_prv[s] = s;
               end else begin
                  p                   = ring_prv[ring_head];
                  ring_nxt[s]         = ring_head;
                  ring_prv[s]         = p;
                  ring_prv[ring_head] = s;
                  ring_nxt[p]         = s;
               end
               ring_head  = s;
               ring_count = ring_count + 1;
            end
         end
         REQ_REMOVE: begin
            if (ring_count == 0) begin
               res.status = ST_EMPTY;
            end else begin
               s   = ring_head;
               hit = 1'b0;
               for (i = 0; i < ring_count; i++) begin
                  if (!hit) begin
                     if (ring_val[s] == v) hit = 1'b1;
                     else s = ring_nxt[s];
                  end
               end
               if (!hit) begin
                  res.status = ST_NOTFOUND;
               end else begin
                  p = ring_prv[s];
                  n = ring_nxt[s];
                  if (s == ring_head) ring_head = n;
                  ring_nxt[p]  = n;
                  ring_prv[n]  = p;
                  ring_busy[s] = 1'b0;
                  if (ring_mark_on && ring_mark == s) ring_mark_on = 1'b0;
                  ring_count = ring_count - 1;
                  if (ring_count == 0) begin
                     ring_head    = '0;
                     ring_mark_on = 1'b0;
                  end
               end
            end
         end
         REQ_BACK: begin
            if (ring_count == 0) res.status = ST_EMPTY;
            else ring_head = ring_prv[ring_head];
         end
         default: ;
      endcase
      res.count    = count_type'(ring_count);
      res.has_mark = ring_mark_on;
      res.mark_val = ring_mark_on ? ring_val[ring_mark] : '0;
      return res;
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic push_req(req_kind_type op, logic [VALUE_W-1:0] value, bit sync);
      ring_req_type item;
      item.op    = op;
      item.value = value;
      item.sync  = sync;
      pending_reqs.push_back(item);
   endtask

   // Driver: a new transfer is offered only after the previous one is taken.
   always @(negedge clock) begin : driver
      int           gap_left;
      bit           calm;
      bit           offer;
      ring_req_type item;
      if (!reset) begin
         if ($urandom_range(0, 199) == 0) calm = !calm;
         if (!(req_tvalid && !req_taken)) begin
            offer = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_reqs.size() > 0 &&
                         !(pending_reqs[0].sync && expected_results.size() != 0)) begin
               item      = pending_reqs.pop_front();
               req_tdata <= item.value;
               req_tuser <= item.op;
               offer     = 1'b1;
               gap_left  = calm ? 0 : pick_gap();
            end
            req_tvalid <= offer;
         end
      end
   end

   // Receiver: random stalls, plus two long hold-offs that back up the block.
   always @(negedge clock) begin : sink
      int stall_left;
      int hold_left;
      int holds_done;
      bit calm;
      bit ready;
      if (!reset) begin
         if ($urandom_range(0, 199) == 0) calm = !calm;
         ready = 1'b0;
         if (hold_left > 0) begin
            hold_left--;
         end else if ((holds_done == 0 && results_seen >= 400) ||
                      (holds_done == 1 && results_seen >= 1100)) begin
            hold_left = HOLD_CYCLES;
            holds_done++;
         end else if (stall_left > 0) begin
            stall_left--;
         end else begin
            ready = 1'b1;
            if (!calm && $urandom_range(0, 99) < 25) stall_left = pick_gap();
         end
         rsp_tready <= ready;
      end
   end

   // Monitor: predicts on each request transfer, checks each result transfer.
   always @(posedge clock) begin : monitor
      result_type got;
      result_type want;
      req_taken = 1'b0;
      if (!reset) begin
         idle_cycles++;
         if (req_tvalid && req_tready) begin
            req_taken   = 1'b1;
            idle_cycles = 0;
            expected_results.push_back(ring_apply(req_kind_type'(req_tuser), req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            idle_cycles = 0;
            results_seen++;
            got.status   = status_type'(rsp_tuser[1:0]);
            got.has_mark = rsp_tuser[2];
            got.elem     = rsp_tdata[31:0];
            got.count    = rsp_tdata[36:32];
            got.mark_val = rsp_tdata[68:37];
            if (expected_results.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_MAX)
                  $display("result %0d arrived with nothing expected", results_seen);
            end else begin
               want = expected_results.pop_front();
               if (got !== want || rsp_tdata[71:69] !== 3'b000) begin
                  fail_count++;
                  if (fail_count <= REPORT_MAX) begin
                     $display("result %0d mismatch: expected status %0d elem %h count %0d mark %b/%h",
                              results_seen, want.status, want.elem, want.count,
                              want.has_mark, want.mark_val);
                     $display("   got status %0d elem %h count %0d mark %b/%h pad %b",
                              rsp_tuser[1:0], got.elem, got.count, got.has_mark,
                              got.mark_val, rsp_tdata[71:69]);
                  end
               end
            end
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("no transfer for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      int           k;
      int           r;
      int           burst_left;
      int           add_pct;
      int           next_pct;
      int           remove_pct;
      mix_type      mix;
      req_kind_type op;
      logic [VALUE_W-1:0] value;

      value_pool[0] = '0;
      value_pool[1] = '1;
      for (k = 2; k < POOL_SIZE; k++) value_pool[k] = $urandom;

      // Errors on an empty ring, then the marker rules on a two-element ring.
      push_req(REQ_NEXT, 32'hDEAD_BEEF, 1'b0);
      push_req(REQ_REMOVE, '0, 1'b0);
      push_req(REQ_BACK, '1, 1'b0);
      push_req(REQ_ADD, '1, 1'b0);
      push_req(REQ_ADD, '0, 1'b0);
      push_req(REQ_NEXT, '0, 1'b0);
      // Stepping back onto the marked head leaves the marker alone.
      push_req(REQ_BACK, '0, 1'b0);
      push_req(REQ_REMOVE, '0, 1'b0);
      push_req(REQ_REMOVE, 32'h0000_0005, 1'b0);
      push_req(REQ_REMOVE, '1, 1'b0);
      // Fill to capacity, then one add too many.
      for (k = 0; k < CAPACITY; k++) push_req(REQ_ADD, value_pool[k + 2], 1'b0);
      push_req(REQ_ADD, 32'h1234_5678, 1'b0);

      burst_left = 0;
      mix        = MIX_EVEN;
      for (k = 0; k < RANDOM_ITEMS; k++) begin
         if (burst_left == 0) begin
            mix        = mix_type'($urandom_range(0, 2));
            burst_left = $urandom_range(20, 60);
         end
         burst_left--;
         case (mix)
            MIX_FILL:  begin add_pct = 55; next_pct = 20; remove_pct = 15; end
            MIX_DRAIN: begin add_pct = 15; next_pct = 15; remove_pct = 60; end
            default:   begin add_pct = 35; next_pct = 25; remove_pct = 25; end
         endcase
         r = $urandom_range(0, 99);
         if (r < add_pct) op = REQ_ADD;
         else if (r < add_pct + next_pct) op = REQ_NEXT;
         else if (r < add_pct + next_pct + remove_pct) op = REQ_REMOVE;
         else op = REQ_BACK;
         if ((op == REQ_ADD || op == REQ_REMOVE) && $urandom_range(0, 99) < 85)
            value = value_pool[$urandom_range(0, POOL_SIZE - 1)];
         else
            value = $urandom;
         push_req(op, value, (k % 350) == 349);
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_tvalid || expected_results.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (fail_count == 0 && expected_results.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
